// ===== rtl/core/c6502_pkg.sv =====
// Package for the 6502 execute unit: operation codes, flag positions,
// the decoded item type and reset values. No dependencies.
package c6502_pkg;

  localparam int unsigned QueueDepth = 2;

  // Operation codes in alphabetical mnemonic order.
  localparam logic [5:0] OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3;
  localparam logic [5:0] OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7;
  localparam logic [5:0] OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BRK = 6'd10, OP_BVC = 6'd11;
  localparam logic [5:0] OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14, OP_CLI = 6'd15;
  localparam logic [5:0] OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19;
  localparam logic [5:0] OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23;
  localparam logic [5:0] OP_INC = 6'd24, OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27;
  localparam logic [5:0] OP_JSR = 6'd28, OP_LDA = 6'd29, OP_LDX = 6'd30, OP_LDY = 6'd31;
  localparam logic [5:0] OP_LSR = 6'd32, OP_ORA = 6'd34, OP_PHA = 6'd35;
  localparam logic [5:0] OP_PHP = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_ROL = 6'd39;
  localparam logic [5:0] OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SBC = 6'd43;
  localparam logic [5:0] OP_SEC = 6'd44, OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47;
  localparam logic [5:0] OP_STX = 6'd48, OP_STY = 6'd49, OP_TAX = 6'd50, OP_TAY = 6'd51;
  localparam logic [5:0] OP_TSX = 6'd52, OP_TXA = 6'd53, OP_TXS = 6'd54, OP_TYA = 6'd55;

  // Status bit positions.
  localparam int unsigned FL_C = 0, FL_Z = 1, FL_I = 2, FL_D = 3;
  localparam int unsigned FL_B = 4, FL_U = 5, FL_V = 6, FL_N = 7;

  localparam logic [7:0]  RST_SP = 8'hFD;
  localparam logic [7:0]  RST_P  = 8'h24;
  localparam logic [7:0]  STACK_PAGE = 8'h01;

  // One accepted instruction after the front part has classified it.
  typedef struct packed {
    logic [5:0]  cmd;
    logic [15:0] operand_addr;
    logic        implied;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
    logic [7:0]  data_third;
    logic        is_rmw;     // asl, lsr, rol, ror, inc, dec
    logic        rmw_mem;    // read-modify-write result goes to memory
  } item_t;

endpackage

// ===== rtl/core/cpu6502_execute_unit.sv =====
// Top level of the 6502 execute unit: front queue plus execute back part.
// Depends on c6502_pkg, c6502_front and c6502_back.
//
//   channel | signals                                   | direction
//   in      | in_valid/in_ready, cmd .. data_third      | into block
//   out     | out_valid/out_ready, write_count .. pc_out | out of block
//
// One item per cycle while out_ready is held high; an accepted item is first
// registered in the queue, then executed into the result register on the outputs.
// The execute register and the queue let each side stall on its own.
// Reset sets A, X, Y, PC to zero, S to 0xFD, P to 0x24 and empties the queue.
module cpu6502_execute_unit #(
  parameter int unsigned QueueDepth = c6502_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  cmd,
  input  logic [15:0] operand_addr,
  input  logic        implied,
  input  logic [7:0]  data_first,
  input  logic [7:0]  data_second,
  input  logic [7:0]  data_third,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  write_count,
  output logic [15:0] write_addr,
  output logic [7:0]  write_first,
  output logic [7:0]  write_second,
  output logic [7:0]  write_third,
  output logic [7:0]  acc_out,
  output logic [7:0]  xreg_out,
  output logic [7:0]  yreg_out,
  output logic [7:0]  stack_ptr_out,
  output logic [7:0]  status_out,
  output logic [15:0] pc_out
);
  import c6502_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  c6502_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst, .in_valid, .in_ready, .cmd, .operand_addr, .implied,
    .data_first, .data_second, .data_third, .q_valid, .q_ready, .q_item
  );

  c6502_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item, .out_valid, .out_ready,
    .write_count, .write_addr, .write_first, .write_second, .write_third,
    .acc_out, .xreg_out, .yreg_out, .stack_ptr_out, .status_out, .pc_out
  );

endmodule

// ===== rtl/core/c6502_front.sv =====
// Front part of the 6502 execute unit: accepts items, classifies them and
// holds them in a short queue. Depends on c6502_pkg.
module c6502_front #(
  parameter int unsigned Depth = c6502_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [5:0]        cmd,
  input  logic [15:0]       operand_addr,
  input  logic              implied,
  input  logic [7:0]        data_first,
  input  logic [7:0]        data_second,
  input  logic [7:0]        data_third,
  output logic              q_valid,
  input  logic              q_ready,
  output c6502_pkg::item_t  q_item
);
  import c6502_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t             entries [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  item_t             cls;
  logic              push;
  logic              pop;

  // Classify the incoming instruction.
  always_comb begin
    cls.cmd          = cmd;
    cls.operand_addr = operand_addr;
    cls.implied      = implied;
    cls.data_first   = data_first;
    cls.data_second  = data_second;
    cls.data_third   = data_third;
    cls.is_rmw       = (cmd == OP_ASL) || (cmd == OP_LSR) || (cmd == OP_ROL) ||
                       (cmd == OP_ROR) || (cmd == OP_INC) || (cmd == OP_DEC);
    cls.rmw_mem      = cls.is_rmw && !implied;
  end

  assign in_ready = (count != CntW'(Depth));
  assign q_valid  = (count != '0);
  assign q_item   = entries[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cls;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CntW'(push) - CntW'(pop);
    end
  end

endmodule

// ===== rtl/core/c6502_back.sv =====
// Back part of the 6502 execute unit: holds the register file, executes
// one queued item per cycle unless the output stalls, and registers the result. Depends on c6502_pkg.
module c6502_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  c6502_pkg::item_t  q_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        write_count,
  output logic [15:0]       write_addr,
  output logic [7:0]        write_first,
  output logic [7:0]        write_second,
  output logic [7:0]        write_third,
  output logic [7:0]        acc_out,
  output logic [7:0]        xreg_out,
  output logic [7:0]        yreg_out,
  output logic [7:0]        stack_ptr_out,
  output logic [7:0]        status_out,
  output logic [15:0]       pc_out
);
  import c6502_pkg::*;

  logic [7:0]  acc, xreg, yreg, sp, st;
  logic [15:0] pc;
  logic [7:0]  acc_next, xreg_next, yreg_next, sp_next, st_next;
  logic [15:0] pc_next;
  logic [1:0]  wc_next;
  logic [15:0] wa_next;
  logic [7:0]  w1_next, w2_next, w3_next;
  logic [7:0]  m, rmw_val, cmp_reg, add_m;
  logic [8:0]  sum, diff;
  logic [15:0] pc_inc, pc_dec, stk_addr;
  logic        take, do_exec;

  assign q_ready = !out_valid || out_ready;
  assign do_exec = q_valid && q_ready;

  // Execute one instruction.
  always_comb begin
    m        = q_item.implied ? acc : q_item.data_first;
    pc_inc   = pc + 16'd1;
    pc_dec   = pc - 16'd1;
    stk_addr = {STACK_PAGE, sp};
    add_m    = (q_item.cmd == OP_SBC) ? ~m : m;
    sum      = {1'b0, acc} + {1'b0, add_m} + {8'd0, st[FL_C]};
    cmp_reg  = (q_item.cmd == OP_CPX) ? xreg : (q_item.cmd == OP_CPY) ? yreg : acc;
    diff     = {1'b0, cmp_reg} - {1'b0, m};
    acc_next = acc;
    xreg_next = xreg;
    yreg_next = yreg;
    sp_next  = sp;
    st_next  = st;
    pc_next  = pc;
    wc_next  = 2'd0;
    wa_next  = 16'd0;
    w1_next  = 8'd0;
    w2_next  = 8'd0;
    w3_next  = 8'd0;
    rmw_val  = 8'd0;
    take     = 1'b0;
    case (q_item.cmd)
      OP_ADC, OP_SBC: begin
        acc_next    = sum[7:0];
        st_next[FL_C] = sum[8];
        st_next[FL_V] = ~(acc[7] ^ add_m[7]) & (acc[7] ^ sum[7]);
      end
      OP_AND: acc_next = acc & m;
      OP_ORA: acc_next = acc | m;
      OP_EOR: acc_next = acc ^ m;
      OP_ASL: begin rmw_val = {m[6:0], 1'b0}; st_next[FL_C] = m[7]; end
      OP_LSR: begin rmw_val = {1'b0, m[7:1]}; st_next[FL_C] = m[0]; end
      OP_ROL: begin rmw_val = {m[6:0], st[FL_C]}; st_next[FL_C] = m[7]; end
      OP_ROR: begin rmw_val = {st[FL_C], m[7:1]}; st_next[FL_C] = m[0]; end
      OP_INC: rmw_val = m + 8'd1;
      OP_DEC: rmw_val = m - 8'd1;
      OP_BCC: take = !st[FL_C];
      OP_BCS: take = st[FL_C];
      OP_BEQ: take = st[FL_Z];
      OP_BNE: take = !st[FL_Z];
      OP_BMI: take = st[FL_N];
      OP_BPL: take = !st[FL_N];
      OP_BVC: take = !st[FL_V];
      OP_BVS: take = st[FL_V];
      OP_BIT: begin
        st_next[FL_Z] = ((acc & m) == 8'd0);
        st_next[FL_V] = m[6];
        st_next[FL_N] = m[7];
      end
      OP_BRK: begin
        wc_next = 2'd3;
        wa_next = stk_addr;
        w1_next = pc_inc[15:8];
        w2_next = pc_inc[7:0];
        w3_next = st | 8'h30;
        sp_next = sp - 8'd3;
        st_next[FL_B] = 1'b0;
        st_next[FL_I] = 1'b1;
        pc_next = {q_item.data_second, q_item.data_first};
      end
      OP_CLC: st_next[FL_C] = 1'b0;
      OP_CLD: st_next[FL_D] = 1'b0;
      OP_CLI: st_next[FL_I] = 1'b0;
      OP_CLV: st_next[FL_V] = 1'b0;
      OP_SEC: st_next[FL_C] = 1'b1;
      OP_SED: st_next[FL_D] = 1'b1;
      OP_SEI: st_next[FL_I] = 1'b1;
      OP_CMP, OP_CPX, OP_CPY: begin
        st_next[FL_C] = !diff[8];
        st_next[FL_Z] = (diff[7:0] == 8'd0);
        st_next[FL_N] = diff[7];
      end
      OP_DEX: xreg_next = xreg - 8'd1;
      OP_DEY: yreg_next = yreg - 8'd1;
      OP_INX: xreg_next = xreg + 8'd1;
      OP_INY: yreg_next = yreg + 8'd1;
      OP_JMP: pc_next = q_item.operand_addr;
      OP_JSR: begin
        wc_next = 2'd2;
        wa_next = stk_addr;
        w1_next = pc_dec[15:8];
        w2_next = pc_dec[7:0];
        sp_next = sp - 8'd2;
        pc_next = q_item.operand_addr;
      end
      OP_LDA: acc_next = m;
      OP_LDX: xreg_next = m;
      OP_LDY: yreg_next = m;
      OP_PHA: begin wc_next = 2'd1; wa_next = stk_addr; w1_next = acc; sp_next = sp - 8'd1; end
      OP_PHP: begin
        wc_next = 2'd1; wa_next = stk_addr; w1_next = st | 8'h30; sp_next = sp - 8'd1;
      end
      OP_PLA: begin sp_next = sp + 8'd1; acc_next = q_item.data_first; end
      OP_PLP: begin
        sp_next = sp + 8'd1;
        st_next = (q_item.data_first & 8'hEF) | 8'h20;
      end
      OP_RTI: begin
        sp_next = sp + 8'd3;
        st_next = (q_item.data_first & 8'hEF) | 8'h20;
        pc_next = {q_item.data_third, q_item.data_second};
      end
      OP_RTS: begin
        sp_next = sp + 8'd2;
        pc_next = {q_item.data_second, q_item.data_first} + 16'd1;
      end
      OP_STA: begin wc_next = 2'd1; wa_next = q_item.operand_addr; w1_next = acc; end
      OP_STX: begin wc_next = 2'd1; wa_next = q_item.operand_addr; w1_next = xreg; end
      OP_STY: begin wc_next = 2'd1; wa_next = q_item.operand_addr; w1_next = yreg; end
      OP_TAX: xreg_next = acc;
      OP_TAY: yreg_next = acc;
      OP_TSX: xreg_next = sp;
      OP_TXA: acc_next = xreg;
      OP_TXS: sp_next = xreg;
      OP_TYA: acc_next = yreg;
      default: ;
    endcase

    // Read-modify-write results go to A or to memory.
    if (q_item.is_rmw) begin
      if (q_item.rmw_mem) begin
        wc_next = 2'd1;
        wa_next = q_item.operand_addr;
        w1_next = rmw_val;
      end else begin
        acc_next = rmw_val;
      end
    end
    if (take) begin
      pc_next = pc + q_item.operand_addr;
    end

    // Common N and Z update.
    case (q_item.cmd)
      OP_ADC, OP_SBC, OP_AND, OP_ORA, OP_EOR, OP_LDA, OP_PLA, OP_TXA, OP_TYA: begin
        st_next[FL_Z] = (acc_next == 8'd0);
        st_next[FL_N] = acc_next[7];
      end
      OP_LDX, OP_DEX, OP_INX, OP_TAX, OP_TSX: begin
        st_next[FL_Z] = (xreg_next == 8'd0);
        st_next[FL_N] = xreg_next[7];
      end
      OP_LDY, OP_DEY, OP_INY, OP_TAY: begin
        st_next[FL_Z] = (yreg_next == 8'd0);
        st_next[FL_N] = yreg_next[7];
      end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_INC, OP_DEC: begin
        st_next[FL_Z] = (rmw_val == 8'd0);
        st_next[FL_N] = rmw_val[7];
      end
      default: ;
    endcase
  end

  // Architectural registers and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 8'd0;
      xreg      <= 8'd0;
      yreg      <= 8'd0;
      sp        <= RST_SP;
      st        <= RST_P;
      pc        <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      if (do_exec) begin
        acc  <= acc_next;
        xreg <= xreg_next;
        yreg <= yreg_next;
        sp   <= sp_next;
        st   <= st_next;
        pc   <= pc_next;
      end
      if (q_ready) begin
        out_valid <= q_valid;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (do_exec) begin
      write_count   <= wc_next;
      write_addr    <= wa_next;
      write_first   <= w1_next;
      write_second  <= w2_next;
      write_third   <= w3_next;
      acc_out       <= acc_next;
      xreg_out      <= xreg_next;
      yreg_out      <= yreg_next;
      stack_ptr_out <= sp_next;
      status_out    <= st_next;
      pc_out        <= pc_next;
    end
  end

endmodule
